### rtl/bounded_array_table_macros.svh
// Assertion macros for the bounded array table.
// Included by the top level; needs nothing else.
`ifndef BOUNDED_ARRAY_TABLE_MACROS_SVH
`define BOUNDED_ARRAY_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define BAT_ASSERT(lbl, clk_i, rstn_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
    else $error("bounded_array_table assertion failed");
`define BAT_ASSERT_ALWAYS(lbl, clk_i, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("bounded_array_table assertion failed");
`else
`define BAT_ASSERT(lbl, clk_i, rstn_i, prop)
`define BAT_ASSERT_ALWAYS(lbl, clk_i, prop)
`endif
`endif

### rtl/bat_pkg.sv
// Shared types and constants of the bounded array table.
// Used by bat_ctrl, bat_dp and bounded_array_table; depends on nothing.
package bat_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int VAL_W        = 31;
  localparam int SLOT_W       = 8;
  localparam int CNT_W        = 8;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 48;

  typedef enum logic [1:0] {
    CMD_FIND    = 2'd0,
    CMD_REPLACE = 2'd1,
    CMD_APPEND  = 2'd2,
    CMD_REMOVE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND_RD,
    S_FIND_CMP,
    S_REPL_RD,
    S_REPL_WR,
    S_REM_RD,
    S_REM_CAP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_IDX_SLOT,
    OP_IDX_INC,
    OP_SET_RANGE,
    OP_SET_FULL,
    OP_SET_MISS,
    OP_FIND_HIT,
    OP_REPLACE_WR,
    OP_APPEND_WR,
    OP_REMOVE_CAP,
    OP_SHIFT_WR,
    OP_REMOVE_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic slot_ok;
    logic full;
    logic idx_end;
    logic match;
    logic out_free;
  } sts_t;

endpackage

### rtl/bat_ctrl.sv
// Sequencing state machine of the bounded array table.
// Depends on bat_pkg; drives the datapath in bat_dp through ctl_t.
module bat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  bat_pkg::sts_t sts,
  output bat_pkg::ctl_t ctl
);

  bat_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bat_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bat_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = bat_pkg::S_DISPATCH;
      end
      bat_pkg::S_DISPATCH: begin
        case (sts.cmd)
          bat_pkg::CMD_FIND:    state_nxt = bat_pkg::S_FIND_RD;
          bat_pkg::CMD_REPLACE: state_nxt = sts.slot_ok ? bat_pkg::S_REPL_RD : bat_pkg::S_DONE;
          bat_pkg::CMD_APPEND:  state_nxt = bat_pkg::S_DONE;
          bat_pkg::CMD_REMOVE:  state_nxt = sts.slot_ok ? bat_pkg::S_REM_RD : bat_pkg::S_DONE;
          default:              state_nxt = bat_pkg::S_DONE;
        endcase
      end
      bat_pkg::S_FIND_RD:  state_nxt = sts.idx_end ? bat_pkg::S_DONE : bat_pkg::S_FIND_CMP;
      bat_pkg::S_FIND_CMP: state_nxt = sts.match ? bat_pkg::S_DONE : bat_pkg::S_FIND_RD;
      bat_pkg::S_REPL_RD:  state_nxt = bat_pkg::S_REPL_WR;
      bat_pkg::S_REPL_WR:  state_nxt = bat_pkg::S_DONE;
      bat_pkg::S_REM_RD:   state_nxt = bat_pkg::S_REM_CAP;
      bat_pkg::S_REM_CAP:  state_nxt = bat_pkg::S_SHIFT_RD;
      bat_pkg::S_SHIFT_RD: state_nxt = sts.idx_end ? bat_pkg::S_DONE : bat_pkg::S_SHIFT_WR;
      bat_pkg::S_SHIFT_WR: state_nxt = bat_pkg::S_SHIFT_RD;
      bat_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = bat_pkg::S_IDLE;
      end
      default: state_nxt = bat_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op       = bat_pkg::OP_NONE;
    ctl.out_load = 1'b0;
    in_tready    = 1'b0;
    case (state_r)
      bat_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) ctl.op = bat_pkg::OP_LOAD;
      end
      bat_pkg::S_DISPATCH: begin
        case (sts.cmd)
          bat_pkg::CMD_FIND:    ctl.op = bat_pkg::OP_NONE;
          bat_pkg::CMD_REPLACE,
          bat_pkg::CMD_REMOVE:  ctl.op = sts.slot_ok ? bat_pkg::OP_IDX_SLOT : bat_pkg::OP_SET_RANGE;
          bat_pkg::CMD_APPEND:  ctl.op = sts.full ? bat_pkg::OP_SET_FULL : bat_pkg::OP_APPEND_WR;
          default:              ctl.op = bat_pkg::OP_NONE;
        endcase
      end
      bat_pkg::S_FIND_RD:  ctl.op = sts.idx_end ? bat_pkg::OP_SET_MISS : bat_pkg::OP_READ;
      bat_pkg::S_FIND_CMP: ctl.op = sts.match ? bat_pkg::OP_FIND_HIT : bat_pkg::OP_IDX_INC;
      bat_pkg::S_REPL_RD:  ctl.op = bat_pkg::OP_READ;
      bat_pkg::S_REPL_WR:  ctl.op = bat_pkg::OP_REPLACE_WR;
      bat_pkg::S_REM_RD:   ctl.op = bat_pkg::OP_READ;
      bat_pkg::S_REM_CAP:  ctl.op = bat_pkg::OP_REMOVE_CAP;
      bat_pkg::S_SHIFT_RD: ctl.op = sts.idx_end ? bat_pkg::OP_REMOVE_DONE : bat_pkg::OP_READ;
      bat_pkg::S_SHIFT_WR: ctl.op = bat_pkg::OP_SHIFT_WR;
      bat_pkg::S_DONE:     ctl.out_load = sts.out_free;
      default:             ctl.op = bat_pkg::OP_NONE;
    endcase
  end

endmodule

### rtl/bat_dp.sv
// Datapath of the bounded array table: entry memory, fill count, index
// counter, result registers and the output register. Depends on bat_pkg.
module bat_dp #(
  parameter int CAPACITY = bat_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: slot [7:0], item_value [38:8], zero fill [39]
  input  logic [bat_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: cmd [1:0]
  input  logic [1:0]                       in_tuser,
  input  bat_pkg::ctl_t                    ctl,
  output bat_pkg::sts_t                    sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata: hit_index [7:0], prior_value [38:8], fill_count [46:39], zero fill [47]
  output logic [bat_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: status [1:0]
  output logic [1:0]                       out_tuser
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int SW = 9;

  logic [bat_pkg::VAL_W-1:0] mem [CAPACITY];

  bat_pkg::cmd_t             cmd_r;
  logic [bat_pkg::SLOT_W-1:0] slot_r;
  logic [bat_pkg::VAL_W-1:0] val_r;
  logic [CW-1:0]             occ_r;
  logic [CW-1:0]             idx_r;
  logic [CW-1:0]             idx_m1;
  logic [bat_pkg::VAL_W-1:0] rd_data_r;
  bat_pkg::status_t          status_r;
  logic [bat_pkg::CNT_W-1:0] hit_r;
  logic [bat_pkg::VAL_W-1:0] prior_r;
  logic                      out_valid_r;
  logic [bat_pkg::OUT_DATA_W-1:0] out_data_r;
  bat_pkg::status_t          out_status_r;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [bat_pkg::VAL_W-1:0] mem_wdata;

  assign idx_m1 = idx_r - CW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r[AW-1:0];
    mem_wdata = val_r;
    case (ctl.op)
      bat_pkg::OP_APPEND_WR: begin
        mem_we    = 1'b1;
        mem_waddr = occ_r[AW-1:0];
      end
      bat_pkg::OP_REPLACE_WR: mem_we = 1'b1;
      bat_pkg::OP_SHIFT_WR: begin
        // Each later entry moves one place toward the front.
        mem_we    = 1'b1;
        mem_waddr = idx_m1[AW-1:0];
        mem_wdata = rd_data_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (ctl.op == bat_pkg::OP_READ) rd_data_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (ctl.op == bat_pkg::OP_APPEND_WR) begin
      occ_r <= occ_r + CW'(1);
    end else if (ctl.op == bat_pkg::OP_REMOVE_DONE) begin
      occ_r <= occ_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      bat_pkg::OP_LOAD: begin
        cmd_r    <= bat_pkg::cmd_t'(in_tuser);
        slot_r   <= in_tdata[7:0];
        val_r    <= in_tdata[38:8];
        idx_r    <= '0;
        status_r <= bat_pkg::ST_OK;
        hit_r    <= '0;
        prior_r  <= '0;
      end
      bat_pkg::OP_IDX_SLOT:   idx_r    <= CW'(slot_r);
      bat_pkg::OP_IDX_INC:    idx_r    <= idx_r + CW'(1);
      bat_pkg::OP_SET_RANGE:  status_r <= bat_pkg::ST_RANGE;
      bat_pkg::OP_SET_FULL:   status_r <= bat_pkg::ST_FULL;
      bat_pkg::OP_SET_MISS:   status_r <= bat_pkg::ST_NOT_FOUND;
      bat_pkg::OP_FIND_HIT:   hit_r    <= bat_pkg::CNT_W'(idx_r);
      bat_pkg::OP_REPLACE_WR: prior_r  <= rd_data_r;
      bat_pkg::OP_REMOVE_CAP: begin
        prior_r <= rd_data_r;
        idx_r   <= idx_r + CW'(1);
      end
      bat_pkg::OP_SHIFT_WR:   idx_r    <= idx_r + CW'(1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r   <= {1'b0, bat_pkg::CNT_W'(occ_r), prior_r, hit_r};
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  assign sts.cmd      = cmd_r;
  assign sts.slot_ok  = SW'(slot_r) < SW'(occ_r);
  assign sts.full     = occ_r == CW'(CAPACITY);
  assign sts.idx_end  = idx_r == occ_r;
  assign sts.match    = rd_data_r == val_r;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

### rtl/bounded_array_table.sv
// Channel  Direction  Ports                         Payload
// in       slave      in_tvalid/tready/tdata/tuser  cmd, slot, item_value
// out      master     out_tvalid/tready/tdata/tuser status, hit_index, prior_value, fill_count
//
// One request is in work at a time; a new one is taken while the last result waits.
// Find reads and compares the held entries in turn from the front until a hit or the fill
// count; remove reads the slot entry, then moves each later entry one place toward the front.
// Synchronous active-low reset clears only the fill count, the output valid and control; the count bounds reads.
// A stalled result holds in the output register; the block then waits in its last state.
module bounded_array_table #(
  parameter int CAPACITY = bat_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata: slot [7:0], item_value [38:8], zero fill [39]
  input  logic [bat_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: cmd [1:0]
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata: hit_index [7:0], prior_value [38:8], fill_count [46:39], zero fill [47]
  output logic [bat_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status [1:0]
  output logic [1:0]                     out_tuser
);

  `include "bounded_array_table_macros.svh"

  bat_pkg::ctl_t ctl;
  bat_pkg::sts_t sts;

  bat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  bat_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // A taken request keeps the input closed until its result is built.
  `BAT_ASSERT(a_one_in_work, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)
  `BAT_ASSERT(a_miss_no_hit, clk, rst_n, (out_tvalid && out_tuser == bat_pkg::ST_NOT_FOUND) |-> (out_tdata[7:0] == 8'd0))
  `BAT_ASSERT(a_range_no_prior, clk, rst_n, (out_tvalid && out_tuser == bat_pkg::ST_RANGE) |-> (out_tdata[38:8] == 31'd0))
  `BAT_ASSERT_ALWAYS(a_load_only_free, clk, ctl.out_load |-> sts.out_free)

endmodule
